@@ hw/rtl/rfc_pkg.sv @@
`timescale 1ns / 1ps

package rfc_pkg;

    localparam int HEADER_BYTES = 24;
    localparam int NONCE_BYTES  = 16;
    localparam int FRAME_BYTES  = HEADER_BYTES + NONCE_BYTES;

    localparam logic [7:0] POS_VERSION  = 8'd4;
    localparam logic [7:0] POS_KIND     = 8'd6;
    localparam logic [7:0] POS_LENGTH   = 8'd8;
    localparam logic [7:0] SEQ_OFFSET   = 8'd12;
    localparam logic [7:0] CKSUM_OFFSET = 8'd20;
    localparam logic [7:0] HDR_END      = 8'(HEADER_BYTES);
    localparam logic [7:0] NONCE_END    = 8'(FRAME_BYTES);
    localparam logic [7:0] COUNT_MAX    = 8'hFF;

    localparam logic [31:0] MAGIC_WORD  = 32'h3154_4C42;
    localparam logic [15:0] READY_KIND  = 16'd1;
    localparam logic [31:0] LEN_EXPECT  = 32'(NONCE_BYTES);
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

    localparam logic [1:0] REG_VERSION     = 2'd0;
    localparam logic [1:0] REG_NONCE_LOW   = 2'd1;
    localparam logic [1:0] REG_NONCE_HIGH  = 2'd2;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_LENGTH   = 3'd1;
    localparam status_t ST_MAGIC    = 3'd2;
    localparam status_t ST_VERSION  = 3'd3;
    localparam status_t ST_KIND     = 3'd4;
    localparam status_t ST_SEQUENCE = 3'd5;
    localparam status_t ST_CHECKSUM = 3'd6;
    localparam status_t ST_NONCE    = 3'd7;

    typedef struct packed {
        logic       go;
        logic       last;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [15:0]  version;
        logic [127:0] nonce;
    } cfg_t;

endpackage

@@ hw/rtl/rfc_crc_step.sv @@
`timescale 1ns / 1ps

module rfc_crc_step
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? rfc_pkg::CRC_POLY : 32'h0);
        end
        crc_out = c;
    end

endmodule

@@ hw/rtl/rfc_frame_track.sv @@
`timescale 1ns / 1ps

module rfc_frame_track
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rfc_pkg::item_t         item,
    input  rfc_pkg::cfg_t          cfg,
    output rfc_pkg::status_t       status
);

    logic [7:0]  byte_count_reg, byte_count_next;
    logic [31:0] crc_reg, crc_next, crc_step;
    logic [31:0] cksum_reg, cksum_next;
    logic [31:0] length_reg, length_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] kind_reg, kind_next;
    logic        magic_bad_reg, magic_bad_next;
    logic        seq_nz_reg, seq_nz_next;
    logic        nonce_diff_reg, nonce_diff_next;
    logic [7:0]  pos;
    logic [7:0]  b;
    logic [3:0]  nidx;
    logic [7:0]  nonce_byte;
    logic [7:0]  magic_byte;
    logic [15:0] half_shift;
    logic [31:0] word_shift;

    assign pos = byte_count_reg;
    assign b   = item.data;

    rfc_crc_step u_crc
    (
        .crc_in  (crc_reg),
        .data    (b),
        .crc_out (crc_step)
    );

    assign nidx       = 4'(pos - rfc_pkg::HDR_END);
    assign nonce_byte = 8'(cfg.nonce >> {nidx, 3'b000});
    assign magic_byte = 8'(rfc_pkg::MAGIC_WORD >> {pos[1:0], 3'b000});
    assign half_shift = pos[0] ? {b, 8'h00} : {8'h00, b};
    assign word_shift = {24'h0, b} << {pos[1:0], 3'b000};

    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        cksum_next      = cksum_reg;
        length_next     = length_reg;
        version_next    = version_reg;
        kind_next       = kind_reg;
        magic_bad_next  = magic_bad_reg;
        seq_nz_next     = seq_nz_reg;
        nonce_diff_next = nonce_diff_reg;

        if (pos < rfc_pkg::POS_VERSION)
        begin
            if (b != magic_byte)
            begin
                magic_bad_next = 1'b1;
            end
        end
        else if (pos < rfc_pkg::POS_KIND)
        begin
            version_next = version_reg | half_shift;
        end
        else if (pos < rfc_pkg::POS_LENGTH)
        begin
            kind_next = kind_reg | half_shift;
        end
        else if (pos < rfc_pkg::SEQ_OFFSET)
        begin
            length_next = length_reg | word_shift;
        end
        else if (pos < rfc_pkg::CKSUM_OFFSET)
        begin
            if (b != 8'h00)
            begin
                seq_nz_next = 1'b1;
            end
        end
        else if (pos < rfc_pkg::HDR_END)
        begin
            cksum_next = cksum_reg | word_shift;
        end
        else if (pos < rfc_pkg::NONCE_END)
        begin
            if (b != nonce_byte)
            begin
                nonce_diff_next = 1'b1;
            end
        end

        if (pos < rfc_pkg::CKSUM_OFFSET || pos >= rfc_pkg::HDR_END)
        begin
            crc_next = crc_step;
        end

        if (byte_count_reg != rfc_pkg::COUNT_MAX)
        begin
            byte_count_next = byte_count_reg + 8'd1;
        end
    end

    always_comb
    begin
        if (byte_count_next != rfc_pkg::NONCE_END || length_next != rfc_pkg::LEN_EXPECT)
        begin
            status = rfc_pkg::ST_LENGTH;
        end
        else if (magic_bad_next)
        begin
            status = rfc_pkg::ST_MAGIC;
        end
        else if (version_next != cfg.version)
        begin
            status = rfc_pkg::ST_VERSION;
        end
        else if (kind_next != rfc_pkg::READY_KIND)
        begin
            status = rfc_pkg::ST_KIND;
        end
        else if (seq_nz_next)
        begin
            status = rfc_pkg::ST_SEQUENCE;
        end
        else if (cksum_next != ~crc_next)
        begin
            status = rfc_pkg::ST_CHECKSUM;
        end
        else if (nonce_diff_next)
        begin
            status = rfc_pkg::ST_NONCE;
        end
        else
        begin
            status = rfc_pkg::ST_OK;
        end
    end

    // The end of a frame returns every frame field to its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 8'h00;
            crc_reg        <= rfc_pkg::CRC_INIT;
            cksum_reg      <= 32'h0;
            length_reg     <= 32'h0;
            version_reg    <= 16'h0;
            kind_reg       <= 16'h0;
            magic_bad_reg  <= 1'b0;
            seq_nz_reg     <= 1'b0;
            nonce_diff_reg <= 1'b0;
        end
        else if (item.go)
        begin
            if (item.last)
            begin
                byte_count_reg <= 8'h00;
                crc_reg        <= rfc_pkg::CRC_INIT;
                cksum_reg      <= 32'h0;
                length_reg     <= 32'h0;
                version_reg    <= 16'h0;
                kind_reg       <= 16'h0;
                magic_bad_reg  <= 1'b0;
                seq_nz_reg     <= 1'b0;
                nonce_diff_reg <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                cksum_reg      <= cksum_next;
                length_reg     <= length_next;
                version_reg    <= version_next;
                kind_reg       <= kind_next;
                magic_bad_reg  <= magic_bad_next;
                seq_nz_reg     <= seq_nz_next;
                nonce_diff_reg <= nonce_diff_next;
            end
        end
    end

endmodule

@@ hw/rtl/ready_frame_checker_core.sv @@
`timescale 1ns / 1ps

// Channel    Direction  Contents
// s_axis     in         tdata[7:0] data_byte, tlast last_byte
// m_axis     out        tdata[2:0] status, tdata[7:3] zero
// cfg        in         cfg_we, cfg_index, cfg_data (no read-back)
//
// One byte is taken every cycle unless the input stage stalls; the CRC byte step and the
// header checks sit between the input register and the frame state.
// A status is registered in the output register as the final byte leaves the input register.
// The input stage stalls only when it holds a final byte behind a stalled status transfer.
// Reset clears the frame state and sets the version register to 1 and the nonce to zero.

module ready_frame_checker_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] status, [7:3] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic             in_valid_reg;
    logic             in_last_reg;
    logic [7:0]       in_data_reg;
    logic             out_valid_reg;
    rfc_pkg::status_t out_status_reg;
    logic [15:0]      version_reg;
    logic [63:0]      nonce_low_reg;
    logic [63:0]      nonce_high_reg;
    logic             proc_go;
    rfc_pkg::item_t   item;
    rfc_pkg::cfg_t    cfg;
    rfc_pkg::status_t status;

    assign proc_go       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_go;

    assign item.go     = proc_go;
    assign item.last   = in_last_reg;
    assign item.data   = in_data_reg;
    assign cfg.version = version_reg;
    assign cfg.nonce   = {nonce_high_reg, nonce_low_reg};

    rfc_frame_track u_track
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_go && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && in_last_reg)
        begin
            out_status_reg <= status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg    <= 16'd1;
            nonce_low_reg  <= 64'h0;
            nonce_high_reg <= 64'h0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfc_pkg::REG_VERSION:    version_reg    <= cfg_data[15:0];
                rfc_pkg::REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                rfc_pkg::REG_NONCE_HIGH: nonce_high_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_status_reg};

endmodule

@@ hw/rtl/rfc_checker.sv @@
`timescale 1ns / 1ps

module rfc_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tready,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata
);

    // A waiting status transfer is never withdrawn.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("status transfer dropped while stalled");

    // The input side may only stall behind a full, stalled status register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a pending status");

    // A shown status never carries bits above the status code.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:3] == 5'b00000)
        else $error("status padding not zero");

endmodule

bind ready_frame_checker_core rfc_checker u_rfc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/ready_frame_checker_core_test.sv @@
`timescale 1ns / 1ps

module ready_frame_checker_core_test;

    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum int {
        DEF_NONE,
        DEF_MAGIC,
        DEF_VERSION,
        DEF_KIND,
        DEF_LENGTH_FIELD,
        DEF_SHORT,
        DEF_LONG,
        DEF_SEQUENCE,
        DEF_CHECKSUM,
        DEF_NONCE,
        DEF_NOISE
    } defect_t;

    class frame_scoreboard_t;
        localparam int MAX_REPORTS = 10;

        logic [15:0] version_reg;
        logic [63:0] nonce_lo;
        logic [63:0] nonce_hi;

        logic [7:0]  count;
        logic [31:0] crc;
        logic [31:0] stored_crc;
        logic [31:0] length_word;
        logic [15:0] version_word;
        logic [15:0] kind_word;
        bit          magic_bad;
        bit          seq_nonzero;
        bit          nonce_bad;

        rfc_pkg::status_t pending[$];
        int unsigned mismatches;
        int unsigned frames;
        int unsigned status_seen[8];

        function new();
            version_reg = 16'd1;
            nonce_lo    = '0;
            nonce_hi    = '0;
            mismatches  = 0;
            frames      = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            count        = '0;
            crc          = rfc_pkg::CRC_INIT;
            stored_crc   = '0;
            length_word  = '0;
            version_word = '0;
            kind_word    = '0;
            magic_bad    = 0;
            seq_nonzero  = 0;
            nonce_bad    = 0;
        endfunction

        static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ rfc_pkg::CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                rfc_pkg::REG_VERSION:    version_reg = data[15:0];
                rfc_pkg::REG_NONCE_LOW:  nonce_lo = data;
                rfc_pkg::REG_NONCE_HIGH: nonce_hi = data;
                default: ;
            endcase
        endfunction

        function void note_transfer(logic [7:0] b, bit last);
            int               pos;
            int               idx;
            logic [7:0]       want_byte;
            rfc_pkg::status_t st;
            pos = count;
            if (pos < rfc_pkg::POS_VERSION)
            begin
                if (b != rfc_pkg::MAGIC_WORD[8*pos +: 8])
                    magic_bad = 1;
            end
            else if (pos < rfc_pkg::POS_KIND)
                version_word |= 16'(b) << (8 * (pos - rfc_pkg::POS_VERSION));
            else if (pos < rfc_pkg::POS_LENGTH)
                kind_word |= 16'(b) << (8 * (pos - rfc_pkg::POS_KIND));
            else if (pos < rfc_pkg::SEQ_OFFSET)
                length_word |= 32'(b) << (8 * (pos - rfc_pkg::POS_LENGTH));
            else if (pos < rfc_pkg::CKSUM_OFFSET)
            begin
                if (b != 8'd0)
                    seq_nonzero = 1;
            end
            else if (pos < rfc_pkg::HDR_END)
                stored_crc |= 32'(b) << (8 * (pos - rfc_pkg::CKSUM_OFFSET));
            else if (pos < rfc_pkg::NONCE_END)
            begin
                idx = pos - rfc_pkg::HEADER_BYTES;
                want_byte = (idx < 8) ? nonce_lo[8*idx +: 8] : nonce_hi[8*(idx-8) +: 8];
                if (b != want_byte)
                    nonce_bad = 1;
            end

            if (pos < rfc_pkg::CKSUM_OFFSET || pos >= rfc_pkg::HDR_END)
                crc = crc_step(crc, b);

            if (count != rfc_pkg::COUNT_MAX)
                count++;

            if (!last)
                return;

            if (count != rfc_pkg::NONCE_END || length_word != rfc_pkg::LEN_EXPECT)
                st = rfc_pkg::ST_LENGTH;
            else if (magic_bad)
                st = rfc_pkg::ST_MAGIC;
            else if (version_word != version_reg)
                st = rfc_pkg::ST_VERSION;
            else if (kind_word != rfc_pkg::READY_KIND)
                st = rfc_pkg::ST_KIND;
            else if (seq_nonzero)
                st = rfc_pkg::ST_SEQUENCE;
            else if (stored_crc != ~crc)
                st = rfc_pkg::ST_CHECKSUM;
            else if (nonce_bad)
                st = rfc_pkg::ST_NONCE;
            else
                st = rfc_pkg::ST_OK;
            pending.push_back(st);
            clear_frame();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void check_status(logic [7:0] got);
            rfc_pkg::status_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("status transfer 0x%02h with no frame outstanding", got));
                return;
            end
            want = pending.pop_front();
            frames++;
            status_seen[want]++;
            if (got !== {5'd0, want})
                report($sformatf("frame %0d: expected status %0d, got tdata 0x%02h",
                                 frames, want, got));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [63:0] cfg_data = 64'd0;

    frame_scoreboard_t sb;
    logic [7:0]        frame_q[$];
    int                burst_left = 0;
    int                bytes_sent = 0;
    int                settings = 1;
    int                stall_left = 0;
    int                rx_mode = 0;
    int                rx_cycles = 0;
    int                target_sizes[2] = '{255, 256};

    ready_frame_checker_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    // The receiver periodically picks a new stall behaviour at random.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata);
        rx_cycles++;
        if (rx_cycles % 300 == 0)
            rx_mode = $urandom_range(0, 2);
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rx_mode == 1 && $urandom_range(0, 1) == 0)
                stall_left = $urandom_range(1, 3);
            else if (rx_mode == 2 && $urandom_range(0, 15) == 0)
                stall_left = $urandom_range(5, 30);
        end
    end

    function automatic void flip_byte(int lo, int hi);
        int idx;
        idx = $urandom_range(lo, hi);
        if (idx < frame_q.size())
            frame_q[idx] ^= 8'($urandom_range(1, 255));
    endfunction

    function automatic void build_frame(defect_t first, defect_t second);
        logic [31:0] c;
        bit          spoil_crc;
        int          n;
        defect_t     d;
        frame_q.delete();
        spoil_crc = 0;
        for (int i = 0; i < 4; i++)
            frame_q.push_back(rfc_pkg::MAGIC_WORD[8*i +: 8]);
        frame_q.push_back(sb.version_reg[7:0]);
        frame_q.push_back(sb.version_reg[15:8]);
        frame_q.push_back(rfc_pkg::READY_KIND[7:0]);
        frame_q.push_back(rfc_pkg::READY_KIND[15:8]);
        for (int i = 0; i < 4; i++)
            frame_q.push_back(rfc_pkg::LEN_EXPECT[8*i +: 8]);
        for (int i = 0; i < 12; i++)
            frame_q.push_back(8'd0);
        for (int i = 0; i < rfc_pkg::NONCE_BYTES; i++)
            frame_q.push_back((i < 8) ? sb.nonce_lo[8*i +: 8] : sb.nonce_hi[8*(i-8) +: 8]);

        for (int k = 0; k < 2; k++)
        begin
            d = (k == 0) ? first : second;
            case (d)
                DEF_MAGIC:        flip_byte(0, 3);
                DEF_VERSION:      flip_byte(4, 5);
                DEF_KIND:         flip_byte(6, 7);
                DEF_LENGTH_FIELD: flip_byte(8, 11);
                DEF_SEQUENCE:     flip_byte(12, 19);
                DEF_CHECKSUM:     spoil_crc = 1;
                DEF_NONCE:        flip_byte(rfc_pkg::HEADER_BYTES, rfc_pkg::FRAME_BYTES - 1);
                DEF_SHORT:
                begin
                    n = $urandom_range(1, rfc_pkg::FRAME_BYTES - 1);
                    while (frame_q.size() > n)
                        void'(frame_q.pop_back());
                end
                DEF_LONG:
                begin
                    n = $urandom_range(rfc_pkg::FRAME_BYTES + 1, rfc_pkg::FRAME_BYTES + 24);
                    while (frame_q.size() < n)
                        frame_q.push_back(8'($urandom));
                end
                DEF_NOISE:
                begin
                    frame_q.delete();
                    n = $urandom_range(1, 60);
                    repeat (n)
                        frame_q.push_back(8'($urandom));
                end
                default: ;
            endcase
        end

        if (frame_q.size() >= rfc_pkg::HEADER_BYTES)
        begin
            c = rfc_pkg::CRC_INIT;
            foreach (frame_q[i])
                if (i < rfc_pkg::CKSUM_OFFSET || i >= rfc_pkg::HEADER_BYTES)
                    c = frame_scoreboard_t::crc_step(c, frame_q[i]);
            c = ~c;
            for (int i = 0; i < 4; i++)
                frame_q[rfc_pkg::CKSUM_OFFSET + i] = c[8*i +: 8];
            if (spoil_crc)
                flip_byte(rfc_pkg::CKSUM_OFFSET, rfc_pkg::HEADER_BYTES - 1);
        end
    endfunction

    task automatic send_byte(logic [7:0] b, bit last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_transfer(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_one(logic [1:0] idx, logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_config(logic [63:0] ver_data, logic [63:0] lo, logic [63:0] hi);
        write_one(rfc_pkg::REG_VERSION, ver_data);
        write_one(rfc_pkg::REG_NONCE_LOW, lo);
        write_one(rfc_pkg::REG_NONCE_HIGH, hi);
        write_one(REG_SPARE, {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    initial
    begin
        int      target;
        int      waited;
        int      leftover;
        defect_t first;
        defect_t second;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values, then a single-byte frame.
        build_frame(DEF_NONE, DEF_NONE);
        send_frame();
        frame_q.delete();
        frame_q.push_back(8'($urandom));
        send_frame();

        drain();
        apply_config({$urandom, 16'($urandom), 16'hFFFF}, '1, '1);
        build_frame(DEF_NONE, DEF_NONE);
        send_frame();
        for (int d = DEF_MAGIC; d <= DEF_NONCE; d++)
        begin
            build_frame(defect_t'(d), DEF_NONE);
            send_frame();
        end
        build_frame(DEF_MAGIC, DEF_NONCE);
        send_frame();
        build_frame(DEF_SEQUENCE, DEF_CHECKSUM);
        send_frame();
        build_frame(DEF_VERSION, DEF_KIND);
        send_frame();
        // Over-long frames around and past the point where the byte counter saturates.
        foreach (target_sizes[i])
        begin
            build_frame(DEF_NONE, DEF_NONE);
            while (frame_q.size() < target_sizes[i])
                frame_q.push_back(8'($urandom));
            send_frame();
        end

        drain();
        apply_config(64'd0, 64'd0, 64'd0);
        build_frame(DEF_NONE, DEF_NONE);
        send_frame();
        build_frame(DEF_NONCE, DEF_NONE);
        send_frame();

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            target = bytes_sent + 130;
            while (bytes_sent < target)
            begin
                if ($urandom_range(0, 24) == 0)
                    drain();
                first  = DEF_NONE;
                second = DEF_NONE;
                if ($urandom_range(0, 9) >= 5)
                begin
                    first = defect_t'($urandom_range(DEF_MAGIC, DEF_NOISE));
                    if ($urandom_range(0, 5) == 0)
                        second = defect_t'($urandom_range(DEF_MAGIC, DEF_NOISE));
                end
                build_frame(first, second);
                send_frame();
            end
        end

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        leftover = sb.pending.size();
        if (leftover != 0)
            $display("%0d expected statuses never arrived", leftover);

        $display("Checked %0d frames from %0d bytes under %0d register settings, %0d mismatches.",
                 sb.frames, bytes_sent, settings, sb.mismatches);
        $display("Statuses seen ok/len/magic/ver/kind/seq/crc/nonce: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
                 sb.status_seen[4], sb.status_seen[5], sb.status_seen[6], sb.status_seen[7]);
        if (sb.mismatches == 0 && leftover == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
